// File: src/mavg_pkg.sv
`timescale 1ns / 1ps

package mavg_pkg;

  // Fixed field widths.
  localparam int SampleW = 16;
  localparam int WinW    = 7;

  // Default depth of the sample ring and the window length after reset.
  localparam int MaxWindowDef = 64;
  localparam int ResetWindow  = 16;

  // Depth of the sample queue between the input side and the ring.
  localparam int QueueDepth = 2;

  // Status of the ring stage, seen by the input side and the divider.
  typedef struct packed {
    logic sweep_busy;  // clearing or re-summing the ring
    logic job_valid;   // a new running total waits for the divider
  } ring_status_t;

endpackage

// File: src/moving_average_filter.sv
`timescale 1ns / 1ps
// Channel   Direction  Ports                         Content
// s_axis    in         s_axis_tvalid/tready/tdata    tdata[15:0] = sample (signed)
// m_axis    out        m_axis_tvalid/tready/tdata    tdata[15:0] = average (signed)
// cfg       in         cfg_we_i, cfg_wdata_i         window_length, 7 bits
//
// The serial divider yields one quotient bit per cycle and sets the rate; it takes
// a new total only after its last average has been taken on m_axis.
// After reset the ring is cleared entry by entry with s_axis_tready low.
// A window length write re-sums the first N entries, tready low.
// A two-beat sample queue keeps s_axis taking beats while a result waits on m_axis.

module moving_average_filter import mavg_pkg::*; #(
  parameter int MAX_WINDOW = MaxWindowDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [WinW-1:0]    cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [SampleW-1:0] s_axis_tdata,   // [15:0] sample
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [SampleW-1:0] m_axis_tdata    // [15:0] average
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int TW = SampleW + AW;

  ring_status_t              ring_stat;
  logic                      q_valid;
  logic [SampleW-1:0]        q_data;
  logic                      q_pop;
  logic                      div_take;
  logic signed [TW-1:0]      total;
  logic [WinW-1:0]           win;

  mavg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .hold_i        (ring_stat.sweep_busy),
    .pop_i         (q_pop),
    .valid_o       (q_valid),
    .data_o        (q_data)
  );

  mavg_ring #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .smp_valid_i (q_valid),
    .smp_i       (q_data),
    .pop_o       (q_pop),
    .take_i      (div_take),
    .stat_o      (ring_stat),
    .total_o     (total),
    .win_o       (win)
  );

  mavg_div #(
    .TW (TW)
  ) u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (ring_stat.job_valid),
    .total_i       (total),
    .win_i         (win),
    .take_o        (div_take),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: src/mavg_front.sv
`timescale 1ns / 1ps

module mavg_front import mavg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [SampleW-1:0] s_axis_tdata,   // [15:0] sample
  input  logic               hold_i,
  input  logic               pop_i,
  output logic               valid_o,
  output logic [SampleW-1:0] data_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  logic [SampleW-1:0] slot_q [QueueDepth];
  logic [PtrW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]      cnt_q, cnt_d;
  logic               push;

  always_comb begin
    s_axis_tready = !hold_i && (cnt_q != (PtrW + 1)'(QueueDepth));
    push          = s_axis_tvalid && s_axis_tready;
    valid_o       = (cnt_q != '0);
    data_o        = slot_q[rd_q];

    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + (PtrW + 1)'(1);
    end else if (pop_i && !push) begin
      cnt_d = cnt_q - (PtrW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= s_axis_tdata;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("sample queue popped while empty");

endmodule

// File: src/mavg_ring.sv
`timescale 1ns / 1ps

module mavg_ring import mavg_pkg::*; #(
  parameter  int MAX_WINDOW = MaxWindowDef,
  localparam int AW         = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  localparam int TW         = SampleW + AW
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [WinW-1:0]           cfg_wdata_i,
  input  logic                      smp_valid_i,
  input  logic signed [SampleW-1:0] smp_i,
  output logic                      pop_o,
  input  logic                      take_i,
  output ring_status_t              stat_o,
  output logic signed [TW-1:0]      total_o,
  output logic [WinW-1:0]           win_o
);

  localparam int WinCap = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;
  localparam int RstWin = (ResetWindow < WinCap) ? ResetWindow : WinCap;
  localparam int CW     = (AW + 1 > WinW) ? AW + 1 : WinW;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_SUM_RD,
    ST_SUM_ACC
  } state_e;

  state_e                     state_q, state_d;
  logic [WinW-1:0]            win_q, win_d, win_cl;
  logic [AW-1:0]              pos_q, pos_d, idx_q, idx_d;
  logic signed [TW-1:0]       tot_q, tot_d;
  logic signed [SampleW-1:0]  smp_q, smp_d;
  logic                       job_q, job_d;
  logic [CW-1:0]              pos_inc, idx_inc;

  logic signed [SampleW-1:0]  mem_q [MAX_WINDOW];
  logic signed [SampleW-1:0]  rdata_q;
  logic [AW-1:0]              raddr, waddr;
  logic signed [SampleW-1:0]  wdata;
  logic                       we;

  always_comb begin
    win_cl = cfg_wdata_i;
    if (cfg_wdata_i == '0) begin
      win_cl = WinW'(1);
    end else if (cfg_wdata_i > WinW'(WinCap)) begin
      win_cl = WinW'(WinCap);
    end

    pos_inc = CW'(pos_q) + CW'(1);
    idx_inc = CW'(idx_q) + CW'(1);

    state_d = state_q;
    win_d   = win_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    tot_d   = tot_q;
    smp_d   = smp_q;
    job_d   = job_q;
    raddr   = pos_q;
    waddr   = pos_q;
    wdata   = smp_q;
    we      = 1'b0;
    pop_o   = 1'b0;

    if (take_i) begin
      job_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = idx_q;
        wdata = '0;
        if (idx_q == AW'(MAX_WINDOW - 1)) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      ST_IDLE: begin
        // The old entry is read at the same edge that takes the sample.
        if (smp_valid_i && (!job_q || take_i)) begin
          pop_o   = 1'b1;
          smp_d   = smp_i;
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        we      = 1'b1;
        tot_d   = tot_q + TW'(smp_q) - TW'(rdata_q);
        pos_d   = (pos_inc == CW'(win_q)) ? '0 : pos_inc[AW-1:0];
        job_d   = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SUM_RD: begin
        raddr   = idx_q;
        state_d = ST_SUM_ACC;
      end
      ST_SUM_ACC: begin
        tot_d = tot_q + TW'(rdata_q);
        if (idx_inc == CW'(win_q)) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d   = idx_inc[AW-1:0];
          state_d = ST_SUM_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A new window length restarts the ring at entry zero and re-forms the
    // total; while clearing, every entry is zero and the total stays zero.
    if (cfg_we_i) begin
      win_d = win_cl;
      pos_d = '0;
      if (state_q != ST_CLEAR) begin
        tot_d   = '0;
        idx_d   = '0;
        state_d = ST_SUM_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      win_q   <= WinW'(RstWin);
      pos_q   <= '0;
      idx_q   <= '0;
      tot_q   <= '0;
      job_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      win_q   <= win_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
      tot_q   <= tot_d;
      job_q   <= job_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q <= smp_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_comb begin
    stat_o.sweep_busy = (state_q == ST_CLEAR) || (state_q == ST_SUM_RD) ||
                        (state_q == ST_SUM_ACC);
    stat_o.job_valid  = job_q;
    total_o           = tot_q;
    win_o             = win_q;
  end

  a_pos_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(pos_q) < CW'(win_q))
    else $error("write position outside the window");

  a_win_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_q != '0) && (win_q <= WinW'(WinCap)))
    else $error("window length out of range");

endmodule

// File: src/mavg_div.sv
`timescale 1ns / 1ps

module mavg_div import mavg_pkg::*; #(
  parameter int TW = SampleW + $clog2(MaxWindowDef)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  input  logic signed [TW-1:0] total_i,
  input  logic [WinW-1:0]      win_i,
  output logic                 take_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [SampleW-1:0]   m_axis_tdata   // [15:0] average
);

  localparam int CntW = $clog2(TW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e             state_q;
  logic [CntW-1:0]    cnt_q;
  logic [TW-1:0]      mag_q;
  logic [WinW:0]      rem_q;
  logic [WinW-1:0]    dvs_q;
  logic               neg_q;
  logic [SampleW-1:0] res_q;

  logic [TW-1:0]      abs_tot;
  logic [WinW:0]      rem_sh, rem_nx;
  logic               ge;
  logic [TW-1:0]      quo_nx;

  // Restoring division of the magnitude, one quotient bit per cycle. The
  // quotient bits shift into the magnitude register from the bottom.
  always_comb begin
    abs_tot = total_i[TW-1] ? (~total_i + TW'(1)) : total_i;
    rem_sh  = {rem_q[WinW-1:0], mag_q[TW-1]};
    ge      = (rem_sh >= {1'b0, dvs_q});
    rem_nx  = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
    quo_nx  = {mag_q[TW-2:0], ge};
    take_o  = (state_q == ST_IDLE) && job_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      mag_q   <= '0;
      rem_q   <= '0;
      dvs_q   <= WinW'(1);
      neg_q   <= 1'b0;
      res_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            mag_q   <= abs_tot;
            neg_q   <= total_i[TW-1];
            dvs_q   <= win_i;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          mag_q <= quo_nx;
          rem_q <= rem_nx;
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(TW - 1)) begin
            res_q   <= neg_q ? -quo_nx[SampleW-1:0] : quo_nx[SampleW-1:0];
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (m_axis_tready) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = (state_q == ST_DONE);
  assign m_axis_tdata  = res_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (rem_q < {1'b0, dvs_q}))
    else $error("partial remainder not below divisor");

  a_gap_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
    else $error("result presented again right after delivery");

endmodule

// File: bench/moving_average_filter_test.sv
`timescale 1ns / 1ps

module moving_average_filter_test;
  import mavg_pkg::*;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [WinW-1:0]    cfg_wdata_i   = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [SampleW-1:0] s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [SampleW-1:0] m_axis_tdata;

  moving_average_filter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the sample ring and its running total.
  logic signed [SampleW-1:0] ring_shadow [MaxWindowDef];
  int unsigned               ring_pos   = 0;
  int                        ring_total = 0;
  int unsigned               window_len = ResetWindow;

  logic [SampleW-1:0] sample_queue[$];
  logic [SampleW-1:0] average_queue[$];

  int unsigned samples_queued  = 0;
  int unsigned beats_accepted  = 0;
  int unsigned averages_seen   = 0;
  int unsigned window_writes   = 0;
  int unsigned mismatch_count  = 0;
  int unsigned hold_requests   = 0;
  int unsigned holds_served    = 0;
  bit          send_idle_on    = 1'b1;
  bit          recv_idle_on    = 1'b1;

  int unsigned send_gap  = 0;
  int unsigned recv_gap  = 0;
  int unsigned hold_left = 0;

  initial begin
    for (int i = 0; i < MaxWindowDef; i++) ring_shadow[i] = '0;
  end

  function automatic void set_window(input logic [WinW-1:0] value);
    int unsigned len;
    len = 32'(value);
    if (len == 0) len = 1;
    if (len > MaxWindowDef) len = MaxWindowDef;
    window_len = len;
    ring_pos   = 0;
    ring_total = 0;
    for (int i = 0; i < len; i++) ring_total += int'(ring_shadow[i]);
  endfunction

  function automatic logic [SampleW-1:0] predict_average(input logic [SampleW-1:0] raw);
    logic signed [SampleW-1:0] smp;
    int                        quotient;
    smp = raw;
    if (ring_pos >= window_len) ring_pos = 0;
    ring_total = ring_total + int'(smp) - int'(ring_shadow[ring_pos]);
    ring_shadow[ring_pos] = smp;
    ring_pos = ring_pos + 1;
    if (ring_pos >= window_len) ring_pos = 0;
    // Signed integer division truncates toward zero.
    quotient = ring_total / int'(window_len);
    return quotient[SampleW-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Sender: offers queued samples, with random gaps between beats.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        average_queue.push_back(predict_average(s_axis_tdata));
        beats_accepted++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // Beat still pending: hold it.
      end else if (send_gap != 0) begin
        send_gap      <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (send_idle_on && $urandom_range(0, 5) == 0) begin
        send_gap      <= $urandom_range(0, 9);
        s_axis_tvalid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        s_axis_tdata  <= sample_queue.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap      <= 0;
      hold_left     <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served  <= holds_served + 1;
      hold_left     <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap      <= recv_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
      recv_gap      <= $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Checker for each average beat.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      averages_seen++;
      if (average_queue.size() == 0) begin
        report_mismatch($sformatf("average %0d with no sample waiting",
                                  $signed(m_axis_tdata)));
      end else if (m_axis_tdata !== average_queue[0]) begin
        report_mismatch($sformatf("average got %0d expected %0d (window %0d)",
                                  $signed(m_axis_tdata), $signed(average_queue[0]),
                                  window_len));
        void'(average_queue.pop_front());
      end else begin
        void'(average_queue.pop_front());
      end
    end
  end

  task automatic queue_sample(input logic [SampleW-1:0] value);
    sample_queue.push_back(value);
    samples_queued++;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (beats_accepted != samples_queued || average_queue.size() != 0);
  endtask

  task automatic write_window(input logic [WinW-1:0] value);
    wait_drained();
    repeat (30) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    set_window(value);
    window_writes++;
  endtask

  // Mostly random samples, with runs of one extreme value, up to 70 long, that can fill
  // the largest window so the running total reaches its limits.
  task automatic queue_random(input int unsigned count);
    logic [SampleW-1:0] extreme;
    int unsigned        run_len;
    int unsigned        done;
    done = 0;
    while (done < count) begin
      case ($urandom_range(0, 79))
        0: begin
          extreme = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
          if ($urandom_range(0, 3) == 0) extreme = $urandom_range(0, 1) ? 16'h0000 : 16'hffff;
          run_len = $urandom_range(1, 70);
          repeat (run_len) queue_sample(extreme);
          done += run_len;
        end
        default: begin
          queue_sample(SampleW'($urandom()));
          done++;
        end
      endcase
    end
  endtask

  initial begin
    logic [WinW-1:0] fixed_windows [8];
    fixed_windows = '{7'd64, 7'd127, 7'd65, 7'd2, 7'd1, 7'd63, 7'd3, 7'd16};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset window of 16.
    queue_sample(16'h7fff); queue_sample(16'h8000); queue_sample(16'h0000);
    queue_sample(16'hffff); queue_sample(16'h0001); queue_sample(16'h8001);
    queue_sample(16'h7ffe); queue_sample(16'h5555); queue_sample(16'haaaa);

    // A zero length is taken as one.
    write_window(7'd0);
    queue_sample(16'h7fff); queue_sample(16'h8000); queue_sample(16'hffff);
    queue_sample(16'h0001); queue_sample(16'hfffe);

    foreach (fixed_windows[i]) begin
      write_window(fixed_windows[i]);
      if (i == 0) begin
        // Sender keeps offering while the receiver holds off, so the block
        // fills up and stalls its input.
        send_idle_on = 1'b0;
        hold_requests++;
        queue_random(150);
        wait_drained();
        send_idle_on = 1'b1;
      end else begin
        send_idle_on = $urandom_range(0, 3) != 0;
        recv_idle_on = $urandom_range(0, 3) != 0;
        queue_random(120);
      end
    end

    repeat (5) begin
      write_window(WinW'($urandom_range(0, 127)));
      send_idle_on = $urandom_range(0, 3) != 0;
      recv_idle_on = $urandom_range(0, 3) != 0;
      queue_random(120);
    end

    // Final stretch at full rate on both sides.
    write_window(WinW'($urandom_range(1, 64)));
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    queue_random(100);

    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("Covered %0d samples and %0d averages across %0d window writes,",
             beats_accepted, averages_seen, window_writes);
    $display("including zero and oversized lengths, extreme runs and a long output stall.");
    if (mismatch_count == 0) begin
      $display("moving_average_filter regression: pass");
    end else begin
      $display("moving_average_filter regression: fail");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Timed out with %0d averages still expected.", average_queue.size());
    $display("moving_average_filter regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
src/mavg_pkg.sv
src/mavg_front.sv
src/mavg_ring.sv
src/mavg_div.sv
src/moving_average_filter.sv
bench/moving_average_filter_test.sv
